>>> rtl/sitda_pkg.sv
// sitda_pkg: shared types, constants and helper functions for the
// signed integer to decimal ascii block. depends on nothing.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int Radix           = 10;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_shift;
    logic top_zero;
    logic rem_one;
    logic neg;
  } sts_t;

  // decimal digits of 2^(w-1), the largest magnitude of a w-bit signed value
  function automatic int decimal_digits(input int w);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        v = v / Radix;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, joins controller and datapath.
// depends on sitda_pkg, sitda_ctrl and sitda_dp.
//
// channel   dir  group           contents
// input     in   s_axis_*        one word: signed value to print
// output    out  m_axis_*        one word per character, tlast on final one
//
// sequence: accept, VALUE_WIDTH double-dabble shifts, a search for the
// leading digit that drops leading zeros, then the characters one by one
// reset: rst is synchronous, active high, clears state machine and out valid
// stalls: a stalled sink holds the character register and the sequencer; a
// new word is taken the cycle after the last character is loaded
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // value [VALUE_WIDTH-1:0], zero padded to whole bytes
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // character [7:0]
  output logic [7:0]                       m_axis_tdata,
  output logic                             m_axis_tlast
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  // sequencer: accept, shift, skip zeros, sign, digits
  sitda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  // magnitude, bcd digits and output character register
  sitda_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .value     (s_axis_tdata[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .character (m_axis_tdata),
    .last      (m_axis_tlast)
  );

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after accept");

  // only minus sign or decimal digits leave the block
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == sitda_pkg::ASCII_MINUS ||
                       (m_axis_tdata >= sitda_pkg::ASCII_ZERO &&
                        m_axis_tdata <= sitda_pkg::ASCII_ZERO + 8'd9)))
    else $error("character outside sign and digit codes");

  // the sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata == sitda_pkg::ASCII_MINUS) |-> !m_axis_tlast)
    else $error("minus sign marked last");

endmodule

>>> rtl/sitda_dp.sv
// sitda_dp: datapath, double-dabble binary to bcd converter, digit
// shifter and output character register. depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_dp #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] value,
  input  sitda_pkg::cmd_t        cmd,
  output sitda_pkg::sts_t        sts,
  output logic [7:0]             character,
  output logic                   last
);

  localparam int D  = sitda_pkg::decimal_digits(VALUE_WIDTH);
  localparam int BW = 4 * D;
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int RW = $clog2(D + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          adj;
  logic [CW-1:0]          cnt;
  logic [RW-1:0]          rem;
  logic                   neg;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < D; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_WIDTH-1];
      mag <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      bcd <= '0;
      cnt <= CW'(VALUE_WIDTH);
      rem <= RW'(D);
    end
    if (cmd.shift) begin
      {bcd, mag} <= {adj[BW-2:0], mag, 1'b0};
      cnt        <= cnt - 1'b1;
    end
    if (cmd.skip) begin
      bcd <= {bcd[BW-5:0], 4'b0000};
      rem <= rem - 1'b1;
    end
    if (cmd.emit_sign) begin
      character <= sitda_pkg::ASCII_MINUS;
      last      <= 1'b0;
    end
    if (cmd.emit_digit) begin
      character <= sitda_pkg::ASCII_ZERO | {4'b0000, bcd[BW-1 -: 4]};
      last      <= (rem == RW'(1));
      bcd       <= {bcd[BW-5:0], 4'b0000};
      rem       <= rem - 1'b1;
    end
  end

  assign sts.last_shift = (cnt == CW'(1));
  assign sts.top_zero   = (bcd[BW-1 -: 4] == 4'd0);
  assign sts.rem_one    = (rem == RW'(1));
  assign sts.neg        = neg;

endmodule

>>> rtl/sitda_ctrl.sv
// sitda_ctrl: controller state machine, sequences conversion, leading
// zero skip and character emission. depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  input  sitda_pkg::sts_t sts,
  output sitda_pkg::cmd_t cmd,
  output logic            in_ready,
  output logic            out_valid
);

  sitda_pkg::state_t state, state_next;
  logic              out_free;
  logic              out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      sitda_pkg::ST_IDLE:  if (in_valid) state_next = sitda_pkg::ST_CONV;
      sitda_pkg::ST_CONV:  if (sts.last_shift) state_next = sitda_pkg::ST_SKIP;
      sitda_pkg::ST_SKIP: begin
        if (!(sts.top_zero && !sts.rem_one)) begin
          state_next = sts.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_SIGN:  if (out_free) state_next = sitda_pkg::ST_DIGIT;
      sitda_pkg::ST_DIGIT: if (out_free && sts.rem_one) state_next = sitda_pkg::ST_IDLE;
      default:             state_next = sitda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      sitda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sitda_pkg::ST_CONV:  cmd.shift      = 1'b1;
      sitda_pkg::ST_SKIP:  cmd.skip       = sts.top_zero && !sts.rem_one;
      sitda_pkg::ST_SIGN:  cmd.emit_sign  = out_free;
      sitda_pkg::ST_DIGIT: cmd.emit_digit = out_free;
      default: ;
    endcase
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sitda_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> tb/sitda_checker.sv
// sitda_checker: watches both stream channels of signed_int_to_decimal_ascii,
// predicts the decimal text of every accepted word and compares it.
// depends on sitda_pkg for the ascii codes and the radix.
`timescale 1ns / 1ps

module sitda_checker #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // value [W-1:0], zero padded to whole bytes
  input  logic [((W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // character [7:0]
  input  logic [7:0]             m_axis_tdata,
  input  logic                   m_axis_tlast,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [7:0] code;
    logic       is_final;
  } text_char_t;

  text_char_t text_q[$];
  int         err_n = 0;

  // magnitude is one bit wider than the value so the most negative one fits
  task automatic push_decimal_text(input logic [W-1:0] v);
    logic [W:0] mag;
    logic [3:0] digs [0:19];
    int         n;
    text_char_t c;
    mag = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    n   = 0;
    do begin
      digs[n] = 4'(mag % sitda_pkg::Radix);
      mag     = mag / sitda_pkg::Radix;
      n++;
    end while (mag != 0);
    if (v[W-1]) begin
      c.code     = sitda_pkg::ASCII_MINUS;
      c.is_final = 1'b0;
      text_q.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.code     = sitda_pkg::ASCII_ZERO + 8'(digs[k]);
      c.is_final = (k == 0);
      text_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        push_decimal_text(s_axis_tdata[W-1:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (text_q.size() == 0) begin
          err_n++;
          $display("%0t: unexpected character word: expected none, actual %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_c = text_q.pop_front();
          if (m_axis_tdata !== exp_c.code) begin
            err_n++;
            $display("%0t: character mismatch: expected %0d, actual %0d",
                     $time, exp_c.code, m_axis_tdata);
          end
          if (m_axis_tlast !== exp_c.is_final) begin
            err_n++;
            $display("%0t: tlast mismatch: expected %0b, actual %0b",
                     $time, exp_c.is_final, m_axis_tlast);
          end
        end
      end
    end
    errors  <= err_n;
    pending <= text_q.size();
  end

endmodule

>>> tb/tb_signed_int_to_decimal_ascii.sv
// tb_signed_int_to_decimal_ascii: stimulus and verdict for the signed
// integer to decimal ascii block. depends on the rtl and sitda_checker.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

  localparam int W          = 32;
  localparam int RAND_WORDS = 160;
  localparam int CYCLE_CAP  = 200000;
  // extra wait after the final drain, longer than one worst case word
  localparam int DRAIN_WAIT = 120;
  localparam int HOLD_LEN   = 400;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // value [31:0]
  logic [((W+7)/8)*8-1:0] s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // character [7:0]
  logic [7:0]             m_axis_tdata;
  logic                   m_axis_tlast;

  int errors;
  int pending;
  int cycle_count = 0;

  // set by the sender to ask the receiver for one long hold-off
  bit hold_req = 1'b0;

  // extremes, digit count boundaries, both signs and alternating bit patterns
  logic [31:0] corner_vals [0:19] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF7,
    32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'd999999999, 32'd1000000000, 32'hC465_3600,
    32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, 32'hFFFF_FF9C
  };

  always #5 clk = ~clk;

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(W)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sitda_checker #(.W(W)) text_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random value, weighted toward every digit count and both signs
  function automatic logic [31:0] pick_value();
    logic [31:0] p10;
    logic [31:0] v;
    int          k;
    p10 = 32'd1;
    k   = $urandom_range(0, 9);
    for (int i = 0; i < k; i++)
      p10 = p10 * 10;
    case ($urandom_range(0, 3))
      0: v = $urandom();                               // all bits random
      1: v = p10 - ($urandom_range(0, 1));             // powers of ten and one below
      2: v = $urandom_range(0, 999);                   // short texts
      default: v = (k == 0) ? $urandom() : ($urandom() % p10);
    endcase
    // negate about half of the values
    if ($urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic [31:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // lower valid and wait until the checker has seen every character
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall patterns in segments, plus one long hold-off
  initial begin
    int hold_cnt;
    int seg;
    int mode;
    bit hold_done;
    hold_cnt      = 0;
    seg           = 0;
    mode          = 0;
    hold_done     = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else if (hold_req && !hold_done) begin
        // sender keeps offering, so the block fills up and drops tready
        hold_done     = 1'b1;
        hold_cnt      = HOLD_LEN - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg  = $urandom_range(10, 80);
        end
        seg--;
        case (mode)
          0: m_axis_tready <= 1'b1;                           // never stalls
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // sender and verdict
  initial begin
    int burst_left;
    int gap;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words, back to back
    foreach (corner_vals[i])
      send_word(corner_vals[i]);
    // first pause: let every character of the directed part come out
    drain();

    burst_left = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 60)
        hold_req = 1'b1;
      if (n == 110)
        drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // some bursts follow straight on with no gap at all
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_word(pick_value());
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
